FILE: rtl/multi_slot_repeat_timer_bank_top_defines.svh
// assertion macros used by the timer bank checker
`ifndef MULTI_SLOT_REPEAT_TIMER_BANK_TOP_DEFINES_SVH
`define MULTI_SLOT_REPEAT_TIMER_BANK_TOP_DEFINES_SVH

// same-cycle implication, masked while reset is high
`define MSTB_ASSERT_NOW(name, ck, rs, pre, post, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, masked while reset is high
`define MSTB_ASSERT_NEXT(name, ck, rs, pre, post, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: rtl/mstb_pkg.sv
package mstb_pkg;

  // field widths
  localparam int ID_W    = 16;
  localparam int TICKS_W = 24;
  localparam int REP_W   = 16;
  localparam int REPS_W  = 18;
  localparam int LIVE_W  = 5;
  localparam int CMD_W   = 2;
  localparam int KIND_W  = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEL  = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_FIRE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DEL   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_QUIET = 2'd3;

  // status codes
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  // register port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-3:0] REG_TIMER_LIMIT = 1'b0;

  // reset values
  localparam logic [LIVE_W-1:0] TIMER_LIMIT_RST = 5'd16;
  localparam logic [ID_W-1:0]   ID_SEQ_RST      = 16'd1;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [TICKS_W-1:0] interval_ticks;
    logic [REP_W-1:0]   repeat_count;
    logic               periodic;
    logic [ID_W-1:0]    target_id;
  } cmd_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] result_kind;
    logic [ID_W-1:0]   timer_id;
    logic              status;
    logic              last;
  } rsp_item_t;

  typedef struct packed {
    logic [ID_W-1:0]          ident;
    logic [TICKS_W-1:0]       interval;
    logic [TICKS_W-1:0]       remaining;
    logic signed [REPS_W-1:0] repeats_left;
    logic                     periodic;
    logic                     disarmed;
  } slot_rec_t;

  // outcome of the shared slot unit for the slot being visited
  typedef struct packed {
    logic      match;
    logic      fire;
    logic      free;
    slot_rec_t rec;
  } slot_upd_t;

endpackage

FILE: rtl/mstb_slot_ram.sv
module mstb_slot_ram #(
  parameter int AW = 4
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  mstb_pkg::slot_rec_t wdata,
  input  logic [AW-1:0]       raddr,
  output mstb_pkg::slot_rec_t rdata
);

  localparam int DEPTH = 1 << AW;

  mstb_pkg::slot_rec_t mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/mstb_slot_alu.sv
module mstb_slot_alu (
  input  mstb_pkg::slot_rec_t           rec,
  input  logic [mstb_pkg::ID_W-1:0]     key,
  output mstb_pkg::slot_upd_t           upd
);

  logic                               fire;
  logic signed [mstb_pkg::REPS_W-1:0] reps;

  // expiry test and repeat bookkeeping
  assign fire = (rec.remaining == '0);
  assign reps = (fire && !rec.periodic) ? rec.repeats_left - 18'sd1 : rec.repeats_left;

  // one tick applied to the visited slot
  always_comb begin
    upd              = '0;
    upd.rec          = rec;
    upd.rec.repeats_left = reps;
    if (fire) begin
      if (reps != 18'sd0) begin
        upd.rec.remaining = rec.interval;
      end
    end else begin
      upd.rec.remaining = rec.remaining - mstb_pkg::TICKS_W'(1);
    end
    upd.fire  = fire;
    upd.free  = !rec.periodic && (reps <= 18'sd0);
    upd.match = (rec.ident == key);
  end

endmodule

FILE: rtl/mstb_cfg.sv
module mstb_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mstb_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [mstb_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [mstb_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic [mstb_pkg::LIVE_W-1:0]       timer_limit
);

  logic hit;

  // register decode on the word address
  assign hit    = (paddr[mstb_pkg::APB_ADDR_W-1:2] == mstb_pkg::REG_TIMER_LIMIT);
  assign pready = 1'b1;
  assign prdata = hit ? mstb_pkg::APB_DATA_W'(timer_limit) : '0;

  // register write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_limit <= mstb_pkg::TIMER_LIMIT_RST;
    end else if (psel && penable && pwrite && hit) begin
      timer_limit <= pwdata[mstb_pkg::LIVE_W-1:0];
    end
  end

endmodule

FILE: rtl/mstb_seq.sv
module mstb_seq #(
  parameter int SLOTS = 16,
  parameter int IDX_W = 4,
  parameter int CNT_W = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  mstb_pkg::cmd_item_t           cmd_data,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output mstb_pkg::rsp_item_t           rsp_data,
  input  logic [mstb_pkg::LIVE_W-1:0]   timer_limit,
  output logic                          ram_we,
  output logic [IDX_W-1:0]              ram_waddr,
  output mstb_pkg::slot_rec_t           ram_wdata,
  output logic [IDX_W-1:0]              ram_raddr,
  input  mstb_pkg::slot_rec_t           ram_rdata,
  output logic [mstb_pkg::ID_W-1:0]     alu_key,
  input  mstb_pkg::slot_upd_t           alu_upd
);

  typedef enum logic [1:0] {S_IDLE, S_TICK, S_ADD, S_DEL} state_t;

  state_t                        state, state_next;
  logic [CNT_W-1:0]              cur, cur_next;
  logic [CNT_W-1:0]              w, w_next;
  logic [CNT_W-1:0]              used, used_next;
  logic [mstb_pkg::LIVE_W-1:0]   live, live_next;
  logic [mstb_pkg::ID_W-1:0]     id_seq, id_seq_next;
  logic [mstb_pkg::ID_W-1:0]     cand, cand_next;
  mstb_pkg::cmd_item_t           item, item_next;
  logic                          pend_valid, pend_valid_next;
  logic [mstb_pkg::ID_W-1:0]     pend_id, pend_id_next;
  logic                          rsp_valid_next;
  mstb_pkg::rsp_item_t           rsp_data_next;
  logic                          out_free;
  logic                          at_end;
  logic                          full;

  assign cmd_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign at_end    = (cur == used);
  assign full      = (live >= timer_limit) || (used >= CNT_W'(SLOTS));
  assign alu_key   = (state == S_DEL) ? item.target_id : cand;
  assign ram_raddr = cur_next[IDX_W-1:0];

  // sequencer: one slot visited per cycle through the shared slot unit, unless a stalled result holds it
  always_comb begin
    state_next      = state;
    cur_next        = cur;
    w_next          = w;
    used_next       = used;
    live_next       = live;
    id_seq_next     = id_seq;
    cand_next       = cand;
    item_next       = item;
    pend_valid_next = pend_valid;
    pend_id_next    = pend_id;
    rsp_valid_next  = rsp_valid && rsp_stall;
    rsp_data_next   = rsp_data;
    ram_we          = 1'b0;
    ram_waddr       = w[IDX_W-1:0];
    ram_wdata       = alu_upd.rec;

    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          item_next       = cmd_data;
          cur_next        = '0;
          w_next          = '0;
          pend_valid_next = 1'b0;
          cand_next       = id_seq;
          case (cmd_data.command)
            mstb_pkg::CMD_TICK: state_next = S_TICK;
            mstb_pkg::CMD_ADD:  state_next = S_ADD;
            mstb_pkg::CMD_DEL:  state_next = S_DEL;
            default:            state_next = S_IDLE;
          endcase
        end
      end

      S_TICK: begin
        if (at_end) begin
          // closing transfer of the tick, flagged last
          if (out_free) begin
            rsp_valid_next        = 1'b1;
            rsp_data_next.status  = mstb_pkg::ST_OK;
            rsp_data_next.last    = 1'b1;
            if (pend_valid) begin
              rsp_data_next.result_kind = mstb_pkg::KIND_FIRE;
              rsp_data_next.timer_id    = pend_id;
            end else begin
              rsp_data_next.result_kind = mstb_pkg::KIND_QUIET;
              rsp_data_next.timer_id    = '0;
            end
            used_next  = w;
            cur_next   = '0;
            state_next = S_IDLE;
          end
        end else if (!(alu_upd.fire && pend_valid && !out_free)) begin
          // a fire is held back one slot so the final one can carry last
          if (alu_upd.fire) begin
            if (pend_valid) begin
              rsp_valid_next            = 1'b1;
              rsp_data_next.result_kind = mstb_pkg::KIND_FIRE;
              rsp_data_next.timer_id    = pend_id;
              rsp_data_next.status      = mstb_pkg::ST_OK;
              rsp_data_next.last        = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_id_next    = ram_rdata.ident;
          end
          // expired slots drop out, survivors are packed down
          if (alu_upd.free) begin
            if (!ram_rdata.disarmed && (live != '0)) begin
              live_next = live - mstb_pkg::LIVE_W'(1);
            end
          end else begin
            ram_we = 1'b1;
            w_next = w + CNT_W'(1);
          end
          cur_next = cur + CNT_W'(1);
        end
      end

      S_ADD: begin
        if (full) begin
          if (out_free) begin
            rsp_valid_next            = 1'b1;
            rsp_data_next.result_kind = mstb_pkg::KIND_ADD;
            rsp_data_next.timer_id    = '0;
            rsp_data_next.status      = mstb_pkg::ST_FAIL;
            rsp_data_next.last        = 1'b1;
            cur_next                  = '0;
            state_next                = S_IDLE;
          end
        end else if (!at_end) begin
          // candidate taken: step it and rescan from the first slot
          if (alu_upd.match) begin
            cand_next = cand + mstb_pkg::ID_W'(1);
            cur_next  = '0;
          end else begin
            cur_next = cur + CNT_W'(1);
          end
        end else if (out_free) begin
          ram_we                 = 1'b1;
          ram_waddr              = used[IDX_W-1:0];
          ram_wdata.ident        = cand;
          ram_wdata.interval     = item.interval_ticks;
          ram_wdata.remaining    = item.interval_ticks;
          ram_wdata.repeats_left = {{(mstb_pkg::REPS_W - mstb_pkg::REP_W){1'b0}},
                                    item.repeat_count};
          ram_wdata.periodic     = item.periodic;
          ram_wdata.disarmed     = 1'b0;
          used_next              = used + CNT_W'(1);
          live_next              = live + mstb_pkg::LIVE_W'(1);
          id_seq_next            = cand;
          rsp_valid_next            = 1'b1;
          rsp_data_next.result_kind = mstb_pkg::KIND_ADD;
          rsp_data_next.timer_id    = cand;
          rsp_data_next.status      = mstb_pkg::ST_OK;
          rsp_data_next.last        = 1'b1;
          cur_next                  = '0;
          state_next                = S_IDLE;
        end
      end

      S_DEL: begin
        if (!at_end) begin
          if (alu_upd.match) begin
            // disarm in place, freed on the next tick
            if (out_free) begin
              ram_we                 = 1'b1;
              ram_waddr              = cur[IDX_W-1:0];
              ram_wdata              = ram_rdata;
              ram_wdata.repeats_left = '0;
              ram_wdata.periodic     = 1'b0;
              ram_wdata.disarmed     = 1'b1;
              if (!ram_rdata.disarmed && (live != '0)) begin
                live_next = live - mstb_pkg::LIVE_W'(1);
              end
              rsp_valid_next            = 1'b1;
              rsp_data_next.result_kind = mstb_pkg::KIND_DEL;
              rsp_data_next.timer_id    = item.target_id;
              rsp_data_next.status      = mstb_pkg::ST_OK;
              rsp_data_next.last        = 1'b1;
              cur_next                  = '0;
              state_next                = S_IDLE;
            end
          end else begin
            cur_next = cur + CNT_W'(1);
          end
        end else if (out_free) begin
          rsp_valid_next            = 1'b1;
          rsp_data_next.result_kind = mstb_pkg::KIND_DEL;
          rsp_data_next.timer_id    = item.target_id;
          rsp_data_next.status      = mstb_pkg::ST_FAIL;
          rsp_data_next.last        = 1'b1;
          cur_next                  = '0;
          state_next                = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cur        <= '0;
      w          <= '0;
      used       <= '0;
      live       <= '0;
      id_seq     <= mstb_pkg::ID_SEQ_RST;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cur        <= cur_next;
      w          <= w_next;
      used       <= used_next;
      live       <= live_next;
      id_seq     <= id_seq_next;
      pend_valid <= pend_valid_next;
      rsp_valid  <= rsp_valid_next;
    end
    cand     <= cand_next;
    item     <= item_next;
    pend_id  <= pend_id_next;
    rsp_data <= rsp_data_next;
  end

endmodule

FILE: rtl/multi_slot_repeat_timer_bank_top.sv
// Timer bank with SLOTS slots, driven by tick, add and delete commands, one at a
// time. Slot records sit in a single-port-read slot memory and every command
// walks the occupied slots one per cycle through one shared update/compare unit,
// unless a result waits on a stalled result side, so the memory read port sets
// the pace. With n occupied slots a tick gives at most n results (a single one
// when nothing fires), each held while the result side stalls, and an add
// rescans from the first slot for every identifier skipped because it is in use.
// A refused add (live count at or above timer_limit, or every slot occupied,
// disarmed slots included until the next tick) answers without walking the
// slots. A finished result waits in the output register while the next command
// is taken. There is no clearing pass after reset. timer_limit sits at byte
// address 0.
module multi_slot_repeat_timer_bank_top #(
  parameter int SLOTS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_stall,
  input  mstb_pkg::cmd_item_t               cmd_data,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output mstb_pkg::rsp_item_t               rsp_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mstb_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [mstb_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [mstb_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  logic [mstb_pkg::LIVE_W-1:0] timer_limit;
  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr;
  mstb_pkg::slot_rec_t         ram_wdata;
  logic [IDX_W-1:0]            ram_raddr;
  mstb_pkg::slot_rec_t         ram_rdata;
  logic [mstb_pkg::ID_W-1:0]   alu_key;
  mstb_pkg::slot_upd_t         alu_upd;

  // configuration register
  mstb_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .timer_limit (timer_limit)
  );

  // slot records
  mstb_slot_ram #(
    .AW (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared slot update and identifier compare
  mstb_slot_alu u_alu (
    .rec (ram_rdata),
    .key (alu_key),
    .upd (alu_upd)
  );

  // command sequencer and result register
  mstb_seq #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd_data    (cmd_data),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp_data    (rsp_data),
    .timer_limit (timer_limit),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .alu_key     (alu_key),
    .alu_upd     (alu_upd)
  );

endmodule

FILE: rtl/mstb_checker.sv
`include "multi_slot_repeat_timer_bank_top_defines.svh"

module mstb_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              cmd_valid,
  input logic                              cmd_stall,
  input mstb_pkg::cmd_item_t               cmd_data,
  input logic                              rsp_valid,
  input logic                              rsp_stall,
  input mstb_pkg::rsp_item_t               rsp_data
);

  // a stalled result stays put
  `MSTB_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "result changed while stalled")

  // a real command that is taken makes the block busy
  `MSTB_ASSERT_NEXT(a_cmd_busy, clk, rst, cmd_valid && !cmd_stall && (cmd_data.command == mstb_pkg::CMD_TICK || cmd_data.command == mstb_pkg::CMD_ADD || cmd_data.command == mstb_pkg::CMD_DEL), cmd_stall, "block took a command without going busy")

  // replies and quiet ticks are always the only transfer of their command
  `MSTB_ASSERT_NOW(a_single_last, clk, rst, rsp_valid && rsp_data.result_kind != mstb_pkg::KIND_FIRE, rsp_data.last == 1'b1, "single result without last")

  // only add and delete replies can report failure
  `MSTB_ASSERT_NOW(a_fail_kind, clk, rst, rsp_valid && rsp_data.status == mstb_pkg::ST_FAIL, rsp_data.result_kind == mstb_pkg::KIND_ADD || rsp_data.result_kind == mstb_pkg::KIND_DEL, "failure status on a tick result")

endmodule

bind multi_slot_repeat_timer_bank_top mstb_checker u_mstb_checker (.*);
